@@ design/pfl_pkg.sv @@
// ----------------------------------------------------------------------------
// pfl_pkg: shared types and constants of the paged free-list allocator
// Field widths, command and status codes, register indexes, sequencer states.
// ----------------------------------------------------------------------------
package pfl_pkg;

  // Fixed payload widths
  localparam int REQ_SIZE_W    = 16;
  localparam int FREE_PAGE_W   = 2;
  localparam int FREE_BLOCK_W  = 8;
  localparam int STATUS_W      = 3;
  localparam int GRANT_PAGE_W  = 2;
  localparam int GRANT_BLOCK_W = 8;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 16;
  localparam int INIT_PAGES_W  = 3;

  // Commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_GRANTED   = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERSIZE  = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_FREED     = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_FOREIGN   = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SIZE    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_PAGES = 1'd1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_READ,
    S_POP
  } pfl_state_e;

endpackage

@@ design/pfl_link_ram.sv @@
// ----------------------------------------------------------------------------
// pfl_link_ram: next-link storage
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pfl_link_ram #(
  parameter int AW = 10,
  parameter int DW = 9
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/pfl_init_sweep.sv @@
// ----------------------------------------------------------------------------
// pfl_init_sweep: link memory initializer
// Writes an ascending chain into every page, one entry per cycle.
// ----------------------------------------------------------------------------
module pfl_init_sweep #(
  parameter int MAX_PAGES       = 4,
  parameter int BLOCKS_PER_PAGE = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  output logic we_o,
  output logic [((MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1) + $clog2(BLOCKS_PER_PAGE) - 1:0]
               addr_o,
  output logic [$clog2(BLOCKS_PER_PAGE):0] data_o
);

  localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int BW = $clog2(BLOCKS_PER_PAGE);
  localparam int LW = BW + 1;
  localparam logic [LW-1:0] LINK_EMPTY = LW'(BLOCKS_PER_PAGE);

  logic          busy_q;
  logic [PW-1:0] page_q;
  logic [BW-1:0] blk_q;
  logic          last_blk;
  logic          last_page;

  assign last_blk  = (blk_q == BW'(BLOCKS_PER_PAGE - 1));
  assign last_page = (page_q == PW'(MAX_PAGES - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      page_q <= '0;
      blk_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      page_q <= '0;
      blk_q  <= '0;
    end else if (busy_q) begin
      if (last_blk) begin
        blk_q <= '0;
        if (last_page) begin
          busy_q <= 1'b0;
        end else begin
          page_q <= page_q + PW'(1);
        end
      end else begin
        blk_q <= blk_q + BW'(1);
      end
    end
  end

  assign busy_o = busy_q;
  assign we_o   = busy_q;
  assign addr_o = {page_q, blk_q};
  // last block of a page terminates the chain
  assign data_o = last_blk ? LINK_EMPTY : (LW'(blk_q) + LW'(1));

endmodule

@@ design/paged_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// paged_free_list_allocator: fixed-size block pool with per-page free lists
// Allocates and frees (page, block) handles; one result per command.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o): command_i 0 allocates a block of
//    request_size_i bytes, 1 frees the handle free_page_i/free_block_i.
//  - Output channel (out_valid_o/out_ready_i): one result per transfer,
//    status_o plus the granted handle (zero unless granted).
//  - Config port: cfg_index_i 0 = block_size, 1 = initial_pages. Writing
//    initial_pages re-initializes the pool.
//  - After the input transfer: a free or an oversize request resolves in
//    S_DECIDE, an allocate from the current page passes S_DECIDE, S_READ
//    and S_POP, and an empty current page makes S_SCAN search the open
//    pages first. One command at a time.
//  - Reset and every initial_pages write start a sweep that rebuilds
//    the link chains of all pages; in_ready_o stays low until it ends.
//  - A finished result sits in an output register; the next command is
//    accepted while it waits. When the receiver stalls, the following
//    result is held back in the sequencer until the register frees.
// ----------------------------------------------------------------------------
module paged_free_list_allocator #(
  parameter int MAX_PAGES       = 4,
  parameter int BLOCKS_PER_PAGE = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // command input
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 command_i,
  input  logic [pfl_pkg::REQ_SIZE_W-1:0]       request_size_i,
  input  logic [pfl_pkg::FREE_PAGE_W-1:0]      free_page_i,
  input  logic [pfl_pkg::FREE_BLOCK_W-1:0]     free_block_i,
  // result output
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [pfl_pkg::STATUS_W-1:0]         status_o,
  output logic [pfl_pkg::GRANT_PAGE_W-1:0]     grant_page_o,
  output logic [pfl_pkg::GRANT_BLOCK_W-1:0]    grant_block_o,
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [pfl_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  logic [pfl_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int BW = $clog2(BLOCKS_PER_PAGE);
  localparam int LW = BW + 1;
  localparam int CW = $clog2(MAX_PAGES + 1);
  localparam logic [LW-1:0] LINK_EMPTY = LW'(BLOCKS_PER_PAGE);

  pfl_pkg::pfl_state_e state_q, state_d;

  // latched command
  logic                               cmd_q;
  logic [pfl_pkg::REQ_SIZE_W-1:0]     req_q;
  logic [pfl_pkg::FREE_PAGE_W-1:0]    fpage_q;
  logic [pfl_pkg::FREE_BLOCK_W-1:0]   fblock_q;

  // pool state
  logic [pfl_pkg::CFG_DATA_W-1:0]     block_size_q;
  logic [CW-1:0]                      pages_open_q, pages_open_d;
  logic [PW-1:0]                      cur_q, cur_d;
  logic [PW-1:0]                      sel_q, sel_d;
  logic [CW-1:0]                      scan_q, scan_d;
  logic [LW-1:0]                      head_q [MAX_PAGES];
  logic [LW-1:0]                      head_d [MAX_PAGES];

  // output register
  logic                               out_valid_q, out_valid_d;
  logic [pfl_pkg::STATUS_W-1:0]       status_q, status_d;
  logic [pfl_pkg::GRANT_PAGE_W-1:0]   gpage_q, gpage_d;
  logic [pfl_pkg::GRANT_BLOCK_W-1:0]  gblock_q, gblock_d;

  // shared head read port
  logic [PW-1:0]                      head_rd_idx;
  logic [LW-1:0]                      head_rd;

  // link memory ports
  logic                               fl_we;
  logic [PW+BW-1:0]                   fl_waddr;
  logic [LW-1:0]                      fl_wdata;
  logic                               ram_we;
  logic [PW+BW-1:0]                   ram_waddr;
  logic [LW-1:0]                      ram_wdata;
  logic [LW-1:0]                      ram_rdata;

  // init sweep
  logic                               sweep_start;
  logic                               sweep_busy;
  logic                               sweep_we;
  logic [PW+BW-1:0]                   sweep_addr;
  logic [LW-1:0]                      sweep_data;

  logic                               slot_free;
  logic                               in_xfer;
  logic [CW-1:0]                      init_n;
  logic [PW-1:0]                      fpage_pw;
  logic [BW-1:0]                      fblock_bw;
  logic                               foreign;

  assign in_ready_o  = (state_q == pfl_pkg::S_IDLE) && !sweep_busy;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign sweep_start = cfg_we_i && (cfg_index_i == pfl_pkg::REG_INITIAL_PAGES);

  // initial_pages clamped to 1..MAX_PAGES
  always_comb begin
    if (cfg_data_i[pfl_pkg::INIT_PAGES_W-1:0] == '0) begin
      init_n = CW'(1);
    end else if (32'(cfg_data_i[pfl_pkg::INIT_PAGES_W-1:0]) > MAX_PAGES) begin
      init_n = CW'(MAX_PAGES);
    end else begin
      init_n = CW'(cfg_data_i[pfl_pkg::INIT_PAGES_W-1:0]);
    end
  end

  assign fpage_pw  = PW'(fpage_q);
  assign fblock_bw = BW'(fblock_q);
  assign foreign   = (32'(fpage_q) >= 32'(pages_open_q)) ||
                     (32'(fblock_q) >= BLOCKS_PER_PAGE);

  // out-of-range page index reads as empty
  assign head_rd = (32'(head_rd_idx) < MAX_PAGES) ? head_q[head_rd_idx] : LINK_EMPTY;

  pfl_init_sweep #(
    .MAX_PAGES       (MAX_PAGES),
    .BLOCKS_PER_PAGE (BLOCKS_PER_PAGE)
  ) u_sweep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sweep_start),
    .busy_o  (sweep_busy),
    .we_o    (sweep_we),
    .addr_o  (sweep_addr),
    .data_o  (sweep_data)
  );

  // sweep owns the write port while busy; no new command is accepted then
  assign ram_we    = sweep_busy ? sweep_we   : fl_we;
  assign ram_waddr = sweep_busy ? sweep_addr : fl_waddr;
  assign ram_wdata = sweep_busy ? sweep_data : fl_wdata;

  pfl_link_ram #(
    .AW (PW + BW),
    .DW (LW)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i ({sel_q, head_rd[BW-1:0]}),
    .rdata_o (ram_rdata)
  );

  // sequencer: next state and actions
  always_comb begin
    state_d      = state_q;
    sel_d        = sel_q;
    scan_d       = scan_q;
    cur_d        = cur_q;
    pages_open_d = pages_open_q;
    head_d       = head_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    status_d     = status_q;
    gpage_d      = gpage_q;
    gblock_d     = gblock_q;
    fl_we        = 1'b0;
    fl_waddr     = {fpage_pw, fblock_bw};
    fl_wdata     = head_rd;
    head_rd_idx  = sel_q;

    case (state_q)
      pfl_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_d = pfl_pkg::S_DECIDE;
        end
      end

      pfl_pkg::S_DECIDE: begin
        if (cmd_q == pfl_pkg::CMD_FREE) begin
          head_rd_idx = fpage_pw;
          if (slot_free) begin
            out_valid_d = 1'b1;
            gpage_d     = '0;
            gblock_d    = '0;
            state_d     = pfl_pkg::S_IDLE;
            if (foreign) begin
              status_d = pfl_pkg::STATUS_FOREIGN;
            end else begin
              // push: link to old head, block becomes head
              fl_we              = 1'b1;
              head_d[fpage_pw]   = LW'(fblock_bw);
              status_d           = pfl_pkg::STATUS_FREED;
            end
          end
        end else begin
          head_rd_idx = cur_q;
          if (req_q > block_size_q) begin
            if (slot_free) begin
              out_valid_d = 1'b1;
              status_d    = pfl_pkg::STATUS_OVERSIZE;
              gpage_d     = '0;
              gblock_d    = '0;
              state_d     = pfl_pkg::S_IDLE;
            end
          end else if ((32'(cur_q) < 32'(pages_open_q)) && (head_rd != LINK_EMPTY)) begin
            sel_d   = cur_q;
            state_d = pfl_pkg::S_READ;
          end else begin
            scan_d  = '0;
            state_d = pfl_pkg::S_SCAN;
          end
        end
      end

      pfl_pkg::S_SCAN: begin
        head_rd_idx = PW'(scan_q);
        if (scan_q < pages_open_q) begin
          if (head_rd != LINK_EMPTY) begin
            sel_d   = PW'(scan_q);
            state_d = pfl_pkg::S_READ;
          end else begin
            scan_d = scan_q + CW'(1);
          end
        end else if (slot_free) begin
          out_valid_d = 1'b1;
          gblock_d    = '0;
          state_d     = pfl_pkg::S_IDLE;
          if (32'(pages_open_q) < MAX_PAGES) begin
            // open a fresh page: block 0 granted, its link (block 1) is the new head
            head_d[PW'(pages_open_q)] = LW'(1);
            pages_open_d              = pages_open_q + CW'(1);
            cur_d                     = PW'(pages_open_q);
            status_d                  = pfl_pkg::STATUS_GRANTED;
            gpage_d                   = pfl_pkg::GRANT_PAGE_W'(PW'(pages_open_q));
          end else begin
            status_d = pfl_pkg::STATUS_EXHAUSTED;
            gpage_d  = '0;
          end
        end
      end

      pfl_pkg::S_READ: begin
        // link of the head block is being read
        state_d = pfl_pkg::S_POP;
      end

      pfl_pkg::S_POP: begin
        if (slot_free) begin
          head_d[sel_q] = ram_rdata;
          cur_d         = sel_q;
          out_valid_d   = 1'b1;
          status_d      = pfl_pkg::STATUS_GRANTED;
          gpage_d       = pfl_pkg::GRANT_PAGE_W'(sel_q);
          gblock_d      = pfl_pkg::GRANT_BLOCK_W'(head_rd[BW-1:0]);
          state_d       = pfl_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = pfl_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfl_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // command latch
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q    <= command_i;
      req_q    <= request_size_i;
      fpage_q  <= free_page_i;
      fblock_q <= free_block_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    gpage_q  <= gpage_d;
    gblock_q <= gblock_d;
  end

  // pool control state; config writes are to arrive only while idle, which the block itself does not enforce
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      block_size_q <= pfl_pkg::CFG_DATA_W'(128);
      pages_open_q <= CW'(1);
      cur_q        <= '0;
      sel_q        <= '0;
      scan_q       <= '0;
      for (int p = 0; p < MAX_PAGES; p++) begin
        head_q[p] <= (p == 0) ? '0 : LINK_EMPTY;
      end
    end else begin
      out_valid_q  <= out_valid_d;
      pages_open_q <= pages_open_d;
      cur_q        <= cur_d;
      sel_q        <= sel_d;
      scan_q       <= scan_d;
      head_q       <= head_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          pfl_pkg::REG_BLOCK_SIZE: begin
            block_size_q <= cfg_data_i;
          end
          pfl_pkg::REG_INITIAL_PAGES: begin
            pages_open_q <= init_n;
            cur_q        <= '0;
            for (int p = 0; p < MAX_PAGES; p++) begin
              head_q[p] <= (32'(p) < 32'(init_n)) ? '0 : LINK_EMPTY;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign grant_page_o  = gpage_q;
  assign grant_block_o = gblock_q;

endmodule

@@ design/pfl_checker.sv @@
// ----------------------------------------------------------------------------
// pfl_checker: port-level checks for the paged free-list allocator
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module pfl_checker #(
  parameter int MAX_PAGES       = 4,
  parameter int BLOCKS_PER_PAGE = 256
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [pfl_pkg::STATUS_W-1:0]      status_o,
  input logic [pfl_pkg::GRANT_PAGE_W-1:0]  grant_page_o,
  input logic [pfl_pkg::GRANT_BLOCK_W-1:0] grant_block_o
);

  // a stalled result stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // one command at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transfer accepted while busy");

  // no handle without a grant
  a_zero_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != pfl_pkg::STATUS_GRANTED) |->
      (grant_page_o == '0) && (grant_block_o == '0))
    else $error("handle reported without grant");

  // granted handle inside the pool
  a_grant_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == pfl_pkg::STATUS_GRANTED) |->
      (32'(grant_page_o) < MAX_PAGES) && (32'(grant_block_o) < BLOCKS_PER_PAGE))
    else $error("granted handle out of range");

endmodule

bind paged_free_list_allocator pfl_checker #(
  .MAX_PAGES       (MAX_PAGES),
  .BLOCKS_PER_PAGE (BLOCKS_PER_PAGE)
) u_pfl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .grant_page_o  (grant_page_o),
  .grant_block_o (grant_block_o)
);
